@@ design/set_assoc_cache_lru_page_invalidate_defines.svh @@
// Assertion macros shared by the cache checker.
`ifndef SET_ASSOC_CACHE_LRU_PAGE_INVALIDATE_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_PAGE_INVALIDATE_DEFINES_SVH

// Implication into the next cycle, sampled on clk_i, off during reset.
`define SACACHE_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

// Implication in the same cycle, sampled on clk_i, off during reset.
`define SACACHE_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

@@ design/sacache_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sacache_pkg;

  // Fixed field widths
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned TAG_W      = 32;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned CLR_OUT_W  = 12;
  localparam int unsigned OUT_DATA_W = 80;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_BITS  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_USED  = 8'd3;

  // Configuration reset values
  localparam logic [4:0] PAGE_BITS_RST  = 5'd12;
  localparam logic [3:0] BLOCK_BITS_RST = 4'd4;
  localparam logic [3:0] SET_BITS_RST   = 4'd4;
  localparam logic [3:0] WAYS_USED_RST  = 4'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC_RD,
    ST_ACC_LOOK,
    ST_ACC_UPD,
    ST_INV_RD,
    ST_INV_LOOK,
    ST_INV_WAY,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic acc_rd;
    logic acc_look;
    logic acc_upd;
    logic inv_rd;
    logic inv_look;
    logic inv_way;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_way;
    logic last_set;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

@@ design/sacache_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sacache_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  req_i,
  input  wire logic                                  we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  output      logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port, registered read
  always_ff @(posedge clk_i) begin
    if (req_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/sacache_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sacache_ctrl (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  input  wire logic                    in_inv_i,
  output      logic                    in_ready_o,
  output      sacache_pkg::ctrl_cmd_t  cmd_o,
  input  wire sacache_pkg::dp_status_t sts_i
);

  sacache_pkg::ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sacache_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      sacache_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = in_inv_i ? sacache_pkg::ST_INV_RD : sacache_pkg::ST_ACC_RD;
        end
      end
      sacache_pkg::ST_ACC_RD: begin
        cmd_o.acc_rd = 1'b1;
        state_d = sacache_pkg::ST_ACC_LOOK;
      end
      sacache_pkg::ST_ACC_LOOK: begin
        cmd_o.acc_look = 1'b1;
        state_d = sacache_pkg::ST_ACC_UPD;
      end
      sacache_pkg::ST_ACC_UPD: begin
        cmd_o.acc_upd = 1'b1;
        state_d = sacache_pkg::ST_DONE;
      end
      sacache_pkg::ST_INV_RD: begin
        cmd_o.inv_rd = 1'b1;
        state_d = sacache_pkg::ST_INV_LOOK;
      end
      sacache_pkg::ST_INV_LOOK: begin
        cmd_o.inv_look = 1'b1;
        state_d = sacache_pkg::ST_INV_WAY;
      end
      sacache_pkg::ST_INV_WAY: begin
        cmd_o.inv_way = 1'b1;
        if (sts_i.last_way) begin
          state_d = sts_i.last_set ? sacache_pkg::ST_DONE : sacache_pkg::ST_INV_RD;
        end
      end
      sacache_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = sacache_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sacache_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/sacache_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sacache_dp #(
  parameter int unsigned MAX_WAYS         = 8,
  parameter int unsigned MAX_SETS         = 256,
  parameter int unsigned PAGE_NUMBER_BITS = 20
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_valid_i,
  input  wire logic [sacache_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [sacache_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                                  in_inv_i,
  input  wire logic [sacache_pkg::ADDR_W-1:0]        in_addr_i,
  input  wire logic [PAGE_NUMBER_BITS-1:0]           in_pn_i,
  input  wire sacache_pkg::ctrl_cmd_t                cmd_i,
  output      sacache_pkg::dp_status_t               sts_o,
  output      logic                                  out_valid_o,
  input  wire logic                                  out_ready_i,
  output      logic [sacache_pkg::OUT_DATA_W-1:0]    out_data_o
);

  localparam int unsigned WAY_IW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned FILL_W  = $clog2(MAX_WAYS + 1);
  localparam int unsigned SET_IW  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned SET_LOG = $clog2(MAX_SETS + 1) - 1;
  localparam int unsigned CLR_W   = $clog2(MAX_SETS * MAX_WAYS + 1);
  localparam int unsigned OUT_PAD = sacache_pkg::OUT_DATA_W - 2 * sacache_pkg::CNT_W
                                    - sacache_pkg::CLR_OUT_W - 1;

  // One RAM row holds a whole set
  typedef struct packed {
    logic [MAX_WAYS-1:0][sacache_pkg::TAG_W-1:0] tag;
    logic [MAX_WAYS-1:0][PAGE_NUMBER_BITS-1:0]   page;
    logic [MAX_WAYS-1:0]                         vld;
    logic [MAX_WAYS-1:0][WAY_IW-1:0]             lru;
    logic [FILL_W-1:0]                           fill;
  } row_t;

  localparam int unsigned ROW_W = $bits(row_t);

  // Remove the first occurrence of a way from the LRU list
  function automatic row_t lru_drop(input row_t r, input logic [WAY_IW-1:0] way);
    row_t                            o;
    logic                            found;
    logic [MAX_WAYS-1:0][WAY_IW-1:0] sh;
    o     = r;
    found = 1'b0;
    sh    = r.lru >> WAY_IW;
    for (int j = 0; j < MAX_WAYS; j++) begin
      if (!found && (FILL_W'(j) < r.fill) && (r.lru[j] == way)) begin
        found = 1'b1;
      end
      if (found) begin
        o.lru[j] = sh[j];
      end
    end
    if (found) begin
      o.fill = r.fill - 1'b1;
    end
    return o;
  endfunction

  // Move a way to the most recently used end
  function automatic row_t lru_touch(input row_t r, input logic [WAY_IW-1:0] way);
    row_t o;
    o = lru_drop(r, way);
    if (o.fill < FILL_W'(MAX_WAYS)) begin
      for (int j = 0; j < MAX_WAYS; j++) begin
        if (FILL_W'(j) == o.fill) begin
          o.lru[j] = way;
        end
      end
      o.fill = o.fill + 1'b1;
    end
    return o;
  endfunction

  // Configuration registers
  logic [4:0] page_bits_q;
  logic [3:0] block_bits_q, set_bits_q, ways_used_q;

  // Item registers
  logic                          inv_q;
  logic [PAGE_NUMBER_BITS-1:0]   pn_q;
  logic [63:0]                   blk_q, blk_d;
  logic [SET_IW-1:0]             set_q;
  logic [sacache_pkg::TAG_W-1:0] tag_q;
  logic                          rv_q;
  row_t                          row_q, row_in, row_nxt;
  logic                          hit_q;
  logic [WAY_IW-1:0]             way_q, w_q;
  logic [CLR_W-1:0]              cleared_q;
  logic [sacache_pkg::CNT_W-1:0] hit_cnt_q, miss_cnt_q;
  logic                          out_valid_q;
  logic [sacache_pkg::OUT_DATA_W-1:0] out_data_q;
  logic [MAX_SETS-1:0]           rowv_q;

  // Effective geometry
  logic [3:0]        sb;
  logic [4:0]        ways_eff;
  logic [SET_IW-1:0] set_mask;
  logic [SET_IW-1:0] acc_set;
  logic [sacache_pkg::TAG_W-1:0] acc_tag;

  always_comb begin
    sb = (set_bits_q > 4'(SET_LOG)) ? 4'(SET_LOG) : set_bits_q;
    if (ways_used_q == 4'd0) begin
      ways_eff = 5'd1;
    end else if ({1'b0, ways_used_q} > 5'(MAX_WAYS)) begin
      ways_eff = 5'(MAX_WAYS);
    end else begin
      ways_eff = {1'b0, ways_used_q};
    end
    set_mask = ~({SET_IW{1'b1}} << sb);
    acc_set  = blk_q[SET_IW-1:0] & set_mask;
    acc_tag  = sacache_pkg::TAG_W'(blk_q >> sb);
  end

  // Physical block address from page number and page offset
  always_comb begin
    logic [63:0] pa;
    pa = (64'(in_pn_i) << page_bits_q)
         | (64'(in_addr_i) & ~(64'hFFFF_FFFF_FFFF_FFFF << page_bits_q));
    blk_d = pa >> block_bits_q;
  end

  // Set RAM
  logic              ram_req, ram_we;
  logic [SET_IW-1:0] ram_addr;
  logic [ROW_W-1:0]  ram_rdata;
  logic              clr_hit, last_way, last_set;

  assign last_way = (5'(w_q) + 5'd1) == ways_eff;
  assign last_set = set_q == set_mask;
  assign ram_we   = cmd_i.acc_upd || (cmd_i.inv_way && last_way);
  assign ram_req  = cmd_i.acc_rd || cmd_i.inv_rd || ram_we;
  assign ram_addr = cmd_i.acc_rd ? acc_set : set_q;

  sacache_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SETS)
  ) u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ROW_W'(row_nxt)),
    .rdata_o (ram_rdata)
  );

  // A row never written reads as empty
  always_comb begin
    row_in = row_t'(ram_rdata);
    if (!rv_q) begin
      row_in.vld  = '0;
      row_in.fill = '0;
    end
  end

  // Hit search and victim choice
  logic              hit_f, inv_f;
  logic [WAY_IW-1:0] hit_w, inv_w, lru_w, way_sel;

  always_comb begin
    logic lru_f;
    hit_f = 1'b0;
    inv_f = 1'b0;
    lru_f = 1'b0;
    hit_w = '0;
    inv_w = '0;
    lru_w = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (!hit_f && (5'(w) < ways_eff) && row_in.vld[w] && (row_in.tag[w] == tag_q)) begin
        hit_f = 1'b1;
        hit_w = WAY_IW'(w);
      end
      if (!inv_f && (5'(w) < ways_eff) && !row_in.vld[w]) begin
        inv_f = 1'b1;
        inv_w = WAY_IW'(w);
      end
      if (!lru_f && (FILL_W'(w) < row_in.fill) && (5'(row_in.lru[w]) < ways_eff)) begin
        lru_f = 1'b1;
        lru_w = row_in.lru[w];
      end
    end
    way_sel = hit_f ? hit_w : (inv_f ? inv_w : lru_w);
  end

  // Row update for fill, touch and invalidate
  assign clr_hit = (5'(w_q) < ways_eff) && row_q.vld[w_q] && (row_q.page[w_q] == pn_q);

  always_comb begin
    row_nxt = row_q;
    if (cmd_i.acc_upd) begin
      if (!hit_q) begin
        row_nxt.tag[way_q]  = tag_q;
        row_nxt.page[way_q] = pn_q;
        row_nxt.vld[way_q]  = 1'b1;
      end
      row_nxt = lru_touch(row_nxt, way_q);
    end else if (cmd_i.inv_way && clr_hit) begin
      row_nxt.vld[w_q] = 1'b0;
      row_nxt = lru_drop(row_nxt, w_q);
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_bits_q  <= sacache_pkg::PAGE_BITS_RST;
      block_bits_q <= sacache_pkg::BLOCK_BITS_RST;
      set_bits_q   <= sacache_pkg::SET_BITS_RST;
      ways_used_q  <= sacache_pkg::WAYS_USED_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sacache_pkg::REG_PAGE_BITS:  page_bits_q  <= cfg_data_i[4:0];
        sacache_pkg::REG_BLOCK_BITS: block_bits_q <= cfg_data_i[3:0];
        sacache_pkg::REG_SET_BITS:   set_bits_q   <= cfg_data_i[3:0];
        sacache_pkg::REG_WAYS_USED:  ways_used_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      inv_q <= in_inv_i;
      pn_q  <= in_pn_i;
      blk_q <= blk_d;
    end
    if (cmd_i.acc_rd) begin
      tag_q <= acc_tag;
    end
    if (cmd_i.acc_rd || cmd_i.inv_rd) begin
      rv_q <= rowv_q[ram_addr];
    end
    if (cmd_i.acc_look || cmd_i.inv_look) begin
      row_q <= row_in;
    end else if (cmd_i.acc_upd || cmd_i.inv_way) begin
      row_q <= row_nxt;
    end
    if (cmd_i.acc_look) begin
      hit_q <= hit_f;
      way_q <= way_sel;
    end
    if (cmd_i.inv_look) begin
      w_q <= '0;
    end else if (cmd_i.inv_way) begin
      w_q <= w_q + 1'b1;
    end
    if (cmd_i.load_out) begin
      logic [CLR_W+sacache_pkg::CLR_OUT_W-1:0] clr_ext;
      clr_ext = {{sacache_pkg::CLR_OUT_W{1'b0}}, cleared_q};
      out_data_q <= {{OUT_PAD{1'b0}}, miss_cnt_q, hit_cnt_q,
                     inv_q ? clr_ext[sacache_pkg::CLR_OUT_W-1:0]
                           : {sacache_pkg::CLR_OUT_W{1'b0}},
                     !inv_q && hit_q};
    end
  end

  // Set pointer, counters, row valid flags, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_q       <= '0;
      cleared_q   <= '0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      rowv_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        set_q     <= '0;
        cleared_q <= '0;
      end else if (cmd_i.acc_rd) begin
        set_q <= acc_set;
      end else if (cmd_i.inv_way && last_way) begin
        set_q <= set_q + 1'b1;
      end
      if (cmd_i.inv_way && clr_hit) begin
        cleared_q <= cleared_q + 1'b1;
      end
      if (cmd_i.acc_upd) begin
        if (hit_q) begin
          hit_cnt_q <= hit_cnt_q + 1'b1;
        end else begin
          miss_cnt_q <= miss_cnt_q + 1'b1;
        end
      end
      if (ram_we) begin
        rowv_q[set_q] <= 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.last_way = last_way;
  assign sts_o.last_set = last_set;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;

endmodule

`default_nettype wire

@@ design/set_assoc_cache_lru_page_invalidate.sv @@
// Tag-only set-associative cache with true LRU replacement. Each transaction on the
// slave stream is an access (tuser 0) or a page invalidate (tuser 1) and yields
// exactly one result transaction. One set lives in one row of a single-port RAM
// (tags, pages, valid bits, LRU list, fill count), and a flip-flop per set marks
// rows written since reset, so the block is usable right after reset with no
// clearing pass. An access is accepted, then steps through row read, tag compare
// and victim choice, row write with LRU update, and result. An invalidate walks
// every active set through the same RAM port, with 2^min(set_bits, log2 MAX_SETS)
// active sets and the effective ways_used ways checked in each. Items are processed
// one at a time; a finished result waits in the output register while the next item
// is accepted. The user must ensure configuration is written only while the block
// is idle; the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_cache_lru_page_invalidate #(
  parameter int unsigned MAX_WAYS         = 8,
  parameter int unsigned MAX_SETS         = 256,
  parameter int unsigned PAGE_NUMBER_BITS = 20
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  // Item stream
  input  wire logic s_axis_tvalid_i,
  output      logic s_axis_tready_o,
  // address, page_number
  input  wire logic [((sacache_pkg::ADDR_W + PAGE_NUMBER_BITS + 7) / 8) * 8 - 1:0]
                    s_axis_tdata_i,
  // cmd
  input  wire logic s_axis_tuser_i,
  // Result stream
  output      logic m_axis_tvalid_o,
  input  wire logic m_axis_tready_i,
  // hit, lines_cleared, hit_total, miss_total
  output      logic [sacache_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // Configuration writes
  input  wire logic cfg_valid_i,
  output      logic cfg_ready_o,
  input  wire logic [sacache_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [sacache_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  sacache_pkg::ctrl_cmd_t  cmd;
  sacache_pkg::dp_status_t sts;

  assign cfg_ready_o = 1'b1;

  // Sequencer
  sacache_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_inv_i   (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // Set storage, lookup and counters
  sacache_dp #(
    .MAX_WAYS         (MAX_WAYS),
    .MAX_SETS         (MAX_SETS),
    .PAGE_NUMBER_BITS (PAGE_NUMBER_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_inv_i    (s_axis_tuser_i),
    .in_addr_i   (s_axis_tdata_i[sacache_pkg::ADDR_W-1:0]),
    .in_pn_i     (s_axis_tdata_i[sacache_pkg::ADDR_W +: PAGE_NUMBER_BITS]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

@@ design/sacache_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "set_assoc_cache_lru_page_invalidate_defines.svh"

module sacache_chk (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic s_axis_tvalid_i,
  input wire logic s_axis_tready_o,
  input wire logic m_axis_tvalid_o,
  input wire logic m_axis_tready_i,
  input wire logic [sacache_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  // A stalled result holds
  `SACACHE_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o), "result changed while stalled")

  // One item in flight: input closes right after a transaction
  `SACACHE_ASSERT_NEXT(a_one_item, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "second item taken while busy")

  // A hit never reports cleared lines
  `SACACHE_ASSERT_NOW(a_hit_no_clear, m_axis_tvalid_o && m_axis_tdata_o[0], m_axis_tdata_o[12:1] == 12'd0, "hit with nonzero lines_cleared")

endmodule

bind set_assoc_cache_lru_page_invalidate sacache_chk u_sacache_chk (.*);

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned WAYS_MAX  = 8;
  localparam int unsigned SETS_MAX  = 256;
  localparam int unsigned SET_LOG2  = 8;
  localparam int unsigned PN_W      = 20;
  localparam int unsigned IN_DATA_W = ((sacache_pkg::ADDR_W + PN_W + 7) / 8) * 8;
  localparam int unsigned CYCLE_LIMIT = 12000000;
  // Index past the register list, writes to it are dropped
  localparam logic [sacache_pkg::CFG_IDX_W-1:0] REG_UNUSED = 8'd4;

  localparam logic CMD_ACCESS     = 1'b0;
  localparam logic CMD_INVALIDATE = 1'b1;

  typedef struct packed {
    logic [2:0]                        pad;
    logic [sacache_pkg::CNT_W-1:0]     miss_total;
    logic [sacache_pkg::CNT_W-1:0]     hit_total;
    logic [sacache_pkg::CLR_OUT_W-1:0] lines_cleared;
    logic                              hit;
  } result_t;

  // Cache shadow and result checker
  class cache_scoreboard;
    bit [31:0]   tag_mem[WAYS_MAX*SETS_MAX];
    bit          line_valid[WAYS_MAX*SETS_MAX];
    bit [PN_W-1:0] line_page[WAYS_MAX*SETS_MAX];
    bit [2:0]    age_list[WAYS_MAX*SETS_MAX];
    int unsigned age_len[SETS_MAX];
    bit [31:0]   hits, misses;
    bit [4:0]    page_log2;
    bit [3:0]    block_log2, set_log2, way_count;
    result_t     pending_results[$];
    int unsigned errors, checked, n_access, n_inval, n_cleared;

    function new();
      page_log2 = sacache_pkg::PAGE_BITS_RST;
      block_log2 = sacache_pkg::BLOCK_BITS_RST;
      set_log2 = sacache_pkg::SET_BITS_RST;
      way_count = sacache_pkg::WAYS_USED_RST;
    endfunction

    function void write_reg(logic [sacache_pkg::CFG_IDX_W-1:0] idx,
                            logic [sacache_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        sacache_pkg::REG_PAGE_BITS:  page_log2 = val[4:0];
        sacache_pkg::REG_BLOCK_BITS: block_log2 = val[3:0];
        sacache_pkg::REG_SET_BITS:   set_log2 = val[3:0];
        sacache_pkg::REG_WAYS_USED:  way_count = val[3:0];
        default: ;
      endcase
    endfunction

    // Remove a way from the recency list of a set
    function void age_drop(int unsigned s, int unsigned w);
      int unsigned n;
      n = age_len[s];
      for (int unsigned i = 0; i < n; i++) begin
        if (age_list[s*WAYS_MAX+i] == w) begin
          for (int unsigned j = i; j + 1 < n; j++)
            age_list[s*WAYS_MAX+j] = age_list[s*WAYS_MAX+j+1];
          age_len[s] = n - 1;
          return;
        end
      end
    endfunction

    function void age_touch(int unsigned s, int unsigned w);
      age_drop(s, w);
      if (age_len[s] < WAYS_MAX) begin
        age_list[s*WAYS_MAX+age_len[s]] = 3'(w);
        age_len[s]++;
      end
    endfunction

    // Predict the result of one accepted transaction
    function void note_item(logic cmd, logic [31:0] addr, logic [PN_W-1:0] pn);
      int unsigned sb, nways, nsets, set_idx, base, victim;
      logic [63:0] phys, blk, off_mask;
      logic [31:0] tag;
      bit done, found;
      result_t r;
      sb = (set_log2 > SET_LOG2) ? SET_LOG2 : set_log2;
      nways = (way_count == 0) ? 1 : ((way_count > WAYS_MAX) ? WAYS_MAX : way_count);
      nsets = 1 << sb;
      r = '0;
      if (cmd == CMD_ACCESS) begin
        n_access++;
        off_mask = (64'd1 << page_log2) - 64'd1;
        phys = ({44'd0, pn} << page_log2) | ({32'd0, addr} & off_mask);
        blk = phys >> block_log2;
        set_idx = 32'(blk & 64'(nsets - 1));
        tag = 32'(blk >> sb);
        base = set_idx * WAYS_MAX;
        done = 0;
        for (int unsigned w = 0; w < nways && !done; w++) begin
          if (line_valid[base+w] && tag_mem[base+w] == tag) begin
            r.hit = 1'b1;
            hits++;
            age_touch(set_idx, w);
            done = 1;
          end
        end
        if (!done) begin
          misses++;
          victim = 0;
          found = 0;
          for (int unsigned w = 0; w < nways && !found; w++)
            if (!line_valid[base+w]) begin
              victim = w;
              found = 1;
            end
          // Oldest active way; stale entries for disabled ways are skipped
          for (int unsigned i = 0; i < age_len[set_idx] && !found; i++)
            if (age_list[base+i] < nways) begin
              victim = age_list[base+i];
              found = 1;
            end
          tag_mem[base+victim] = tag;
          line_valid[base+victim] = 1;
          line_page[base+victim] = pn;
          age_touch(set_idx, victim);
        end
      end else begin
        n_inval++;
        for (int unsigned s = 0; s < nsets; s++)
          for (int unsigned w = 0; w < nways; w++)
            if (line_valid[s*WAYS_MAX+w] && line_page[s*WAYS_MAX+w] == pn) begin
              line_valid[s*WAYS_MAX+w] = 0;
              age_drop(s, w);
              r.lines_cleared++;
            end
        n_cleared += r.lines_cleared;
      end
      r.hit_total = hits;
      r.miss_total = misses;
      pending_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing outstanding, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (got.hit !== want.hit) begin
        $display("%0t: hit mismatch, expected %0d actual %0d", $time, want.hit, got.hit);
        errors++;
      end
      if (got.lines_cleared !== want.lines_cleared) begin
        $display("%0t: lines_cleared mismatch, expected %0d actual %0d",
                 $time, want.lines_cleared, got.lines_cleared);
        errors++;
      end
      if (got.hit_total !== want.hit_total) begin
        $display("%0t: hit_total mismatch, expected %0d actual %0d",
                 $time, want.hit_total, got.hit_total);
        errors++;
      end
      if (got.miss_total !== want.miss_total) begin
        $display("%0t: miss_total mismatch, expected %0d actual %0d",
                 $time, want.miss_total, got.miss_total);
        errors++;
      end
      if (got.pad !== 3'b000) begin
        $display("%0t: pad bits mismatch, expected 0 actual %b", $time, got.pad);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [IN_DATA_W-1:0] s_axis_tdata_i = '0;
  logic s_axis_tuser_i = 1'b0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [sacache_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [sacache_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [sacache_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  cache_scoreboard sb = new();
  bit quiet = 0;
  bit long_stall_req = 0;
  int unsigned cycles = 0;
  logic [31:0] pool_addr[32];
  logic [PN_W-1:0] pool_pn[32];

  always #10 clk_i = ~clk_i;

  set_assoc_cache_lru_page_invalidate i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Result side: check accepted transactions
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(result_t'(m_axis_tdata_o));
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, sb.pending_results.size());
      $display("[set_assoc_cache_lru_page_invalidate] ERROR");
      $finish;
    end
  end

  // Receiver back-pressure: random bursts plus one long hold-off
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_stall_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (400) @(negedge clk_i);
        long_stall_req = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
    end
  end

  task automatic send_item(logic cmd, logic [31:0] addr, logic [PN_W-1:0] pn);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {{(IN_DATA_W-sacache_pkg::ADDR_W-PN_W){1'b0}}, pn, addr};
    s_axis_tuser_i <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_item(cmd, addr, pn);
    @(negedge clk_i);
  endtask

  // Drain the pipeline before touching registers
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [sacache_pkg::CFG_IDX_W-1:0] idx,
                           logic [sacache_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(logic [7:0] pb, logic [7:0] bb, logic [7:0] sbits, logic [7:0] wu);
    wait_idle();
    write_reg(sacache_pkg::REG_PAGE_BITS, pb);
    write_reg(sacache_pkg::REG_BLOCK_BITS, bb);
    write_reg(sacache_pkg::REG_SET_BITS, sbits);
    write_reg(sacache_pkg::REG_WAYS_USED, wu);
  endtask

  // Mostly reuse of a working set so hits, evictions and page clears happen
  task automatic random_items(int unsigned count);
    int unsigned r, k;
    for (int unsigned n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      k = $urandom_range(0, 31);
      if (r < 10) begin
        send_item(CMD_INVALIDATE, $urandom,
                  ($urandom_range(0, 4) == 0) ? PN_W'($urandom) : pool_pn[k]);
      end else if (r < 60) begin
        send_item(CMD_ACCESS, pool_addr[k], pool_pn[k]);
      end else begin
        pool_addr[k] = $urandom;
        pool_pn[k] = ($urandom_range(0, 2) == 0) ? PN_W'($urandom)
                                                 : PN_W'($urandom_range(0, 15));
        send_item(CMD_ACCESS, pool_addr[k], pool_pn[k]);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 32; i++) begin
      pool_addr[i] = $urandom;
      pool_pn[i] = PN_W'($urandom_range(0, 15));
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: field extremes, eviction, page clears
    send_item(CMD_INVALIDATE, 32'h0, 20'h0);
    send_item(CMD_ACCESS, 32'h0, 20'h0);
    send_item(CMD_ACCESS, 32'h0, 20'h0);
    send_item(CMD_ACCESS, 32'hFFFF_FFFF, 20'hF_FFFF);
    send_item(CMD_ACCESS, 32'hFFFF_FFFF, 20'hF_FFFF);
    for (int p = 1; p <= 5; p++)
      send_item(CMD_ACCESS, 32'h0, PN_W'(p));
    send_item(CMD_ACCESS, 32'h0, 20'h0);
    send_item(CMD_ACCESS, 32'h0, 20'h4);
    send_item(CMD_INVALIDATE, 32'hFFFF_FFFF, 20'h3);
    send_item(CMD_INVALIDATE, 32'h0, 20'h3);
    send_item(CMD_INVALIDATE, 32'h0, 20'h7_7777);
    send_item(CMD_ACCESS, 32'h0, 20'h3);
    send_item(CMD_INVALIDATE, 32'h0, 20'hF_FFFF);
    send_item(CMD_ACCESS, 32'h0000_0FF0, 20'h5);
    random_items(160);

    // Smallest sizes, way count of zero acts as one
    set_config(8'd0, 8'd0, 8'd0, 8'd0);
    random_items(160);

    // Largest legal sizes, receiver holds off to fill the block
    set_config(8'd20, 8'd12, 8'd8, 8'd8);
    long_stall_req = 1;
    random_items(180);

    // Out of range: set count and way count saturate, stray index ignored
    set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    write_reg(REG_UNUSED, 8'h5A);
    random_items(160);

    // Fewer ways while old lines stay in place
    set_config(8'd12, 8'd5, 8'd3, 8'd2);
    random_items(180);

    // Random settings, no idling in the final stretch
    set_config(8'($urandom_range(0, 20)), 8'($urandom_range(0, 12)),
               8'($urandom_range(0, 8)), 8'($urandom_range(1, 8)));
    quiet = 1;
    random_items(240);

    s_axis_tvalid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("covered %0d accesses (%0d hits, %0d misses) and %0d page invalidates",
             sb.n_access, sb.hits, sb.misses, sb.n_inval);
    $display("%0d lines cleared, %0d results checked, %0d errors",
             sb.n_cleared, sb.checked, sb.errors);
    if (sb.errors == 0)
      $display("[set_assoc_cache_lru_page_invalidate] OK");
    else
      $display("[set_assoc_cache_lru_page_invalidate] ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/sacache_pkg.sv
design/sacache_ram.sv
design/sacache_ctrl.sv
design/sacache_dp.sv
design/set_assoc_cache_lru_page_invalidate.sv
design/sacache_chk.sv
bench/testbench.sv
